// ----- src/url_dec_pkg.sv -----
// Package for the URL percent decoder: character constants, the decode
// phase type, the queue entry type and the hex digit helpers.
// Depends on nothing; every module of the decoder imports it.
package url_dec_pkg;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] HEX_TEN = 8'd10;

    // Number of result bytes one input byte can cause at most.
    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } phase_t;

    // One queue entry holds all result bytes caused by one input byte.
    typedef struct packed {
        logic [1:0]               cnt;
        logic                     last;
        logic [MAX_RES-1:0][7:0]  bytes;
    } entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[CH_0:CH_9]}) || (c inside {[CH_LA:CH_LF]}) ||
               (c inside {[CH_UA:CH_UF]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[CH_0:CH_9]})
            v = c - CH_0;
        else if (c inside {[CH_LA:CH_LF]})
            v = c - CH_LA + HEX_TEN;
        else if (c inside {[CH_UA:CH_UF]})
            v = c - CH_UA + HEX_TEN;
        else
            v = 8'd0;
        return v[3:0];
    endfunction

endpackage

// ----- src/url_dec_front.sv -----
// Front end of the URL percent decoder: accepts input bytes, tracks the
// pending percent sequence and queues one entry per byte with results.
// Depends on url_dec_pkg.
module url_dec_front
    import url_dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       cfg_wr,
    input  logic       cfg_data,
    input  logic       q_full,
    output logic       q_wr,
    output entry_t     q_entry
);

    phase_t     phase_reg, phase_next, mid_phase;
    logic [7:0] held_reg;
    logic       plus_to_space_reg;
    logic       accept;
    logic       byte_hex;
    logic       byte_pct;
    logic [7:0] mapped;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign byte_hex = is_hex(in_byte);
    assign byte_pct = (in_byte == CH_PCT);
    assign mapped   = (plus_to_space_reg && in_byte == CH_PLUS) ? CH_SP : in_byte;

    // Next state: mid_phase is the phase after the byte, before the flush at text end.
    always_comb
    begin
        case (phase_reg)
            PH_PCT:  mid_phase = byte_hex ? PH_DIG : (byte_pct ? PH_PCT : PH_IDLE);
            PH_DIG:  mid_phase = (!byte_hex && byte_pct) ? PH_PCT : PH_IDLE;
            default: mid_phase = byte_pct ? PH_PCT : PH_IDLE;
        endcase
        if (!accept)
            phase_next = phase_reg;
        else if (in_last)
            phase_next = PH_IDLE;
        else
            phase_next = mid_phase;
    end

    // Outputs: gather the result bytes of this input into one entry.
    always_comb
    begin
        logic [1:0] n;
        logic       consumed;
        n        = 2'd0;
        consumed = 1'b0;
        q_entry  = '0;
        case (phase_reg)
            PH_PCT:
            begin
                if (byte_hex)
                    consumed = 1'b1;
                else
                begin
                    q_entry.bytes[n] = CH_PCT;
                    n = n + 2'd1;
                end
            end
            PH_DIG:
            begin
                consumed = byte_hex;
                if (byte_hex)
                begin
                    q_entry.bytes[n] = {hex_value(held_reg), hex_value(in_byte)};
                    n = n + 2'd1;
                end
                else
                begin
                    q_entry.bytes[n] = CH_PCT;
                    n = n + 2'd1;
                    q_entry.bytes[n] = held_reg;
                    n = n + 2'd1;
                end
            end
            default:
            begin
                consumed = 1'b0;
            end
        endcase
        if (!consumed && !byte_pct)
        begin
            q_entry.bytes[n] = mapped;
            n = n + 2'd1;
        end
        if (in_last)
        begin
            // A digit held at text end is always the byte that just arrived.
            case (mid_phase)
                PH_PCT:
                begin
                    q_entry.bytes[n] = CH_PCT;
                    n = n + 2'd1;
                end
                PH_DIG:
                begin
                    q_entry.bytes[n] = CH_PCT;
                    n = n + 2'd1;
                    q_entry.bytes[n] = in_byte;
                    n = n + 2'd1;
                end
                default:
                begin
                    n = n;
                end
            endcase
        end
        q_entry.cnt  = n;
        q_entry.last = in_last;
        q_wr = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            plus_to_space_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg_wr)
                plus_to_space_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_PCT && byte_hex)
            held_reg <= in_byte;
    end

endmodule

// ----- src/url_dec_fifo.sv -----
// Short queue of result entries between the front and back of the decoder.
// Depends on url_dec_pkg for the entry type.
module url_dec_fifo
    import url_dec_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_entry,
    output logic   q_full,
    input  logic   rd,
    output entry_t head,
    output logic   q_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign head    = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == LAST_PTR) ? '0 : rp_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

// ----- src/url_dec_back.sv -----
// Back end of the URL percent decoder: walks the bytes of the head queue
// entry and presents them one per beat in the output register.
// Depends on url_dec_pkg.
module url_dec_back
    import url_dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head,
    input  logic       q_empty,
    output logic       rd,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       text_end
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       run_end_reg, text_end_reg;
    logic       load, at_end;

    assign load     = !q_empty && (!valid_reg || pop);
    assign at_end   = (idx_reg == head.cnt - 2'd1);
    assign rd       = load && at_end;
    assign empty    = !valid_reg;
    assign out_byte = byte_reg;
    assign run_end  = run_end_reg;
    assign text_end = text_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head.bytes[idx_reg];
            run_end_reg  <= at_end;
            text_end_reg <= at_end && head.last;
        end
    end

endmodule

// ----- src/url_percent_decoder.sv -----
// Top level of the streaming URL percent decoder.
// Depends on url_dec_pkg, url_dec_front, url_dec_fifo and url_dec_back.
//
// Input side: present in_byte and in_last with push; a byte is taken on a
// clock edge where push is high and full is low. Output side: while empty is
// low the oldest result sits on out_byte, run_end and text_end; pop takes it.
// cfg_wr with cfg_data sets the plus-to-space mode; the user is to do so between texts, the block does not enforce it.
//
// The front decodes one byte per cycle while the queue is not full and writes
// its one to three result bytes, if any, as one entry into a queue of
// FIFO_DEPTH entries. The back drains that queue one result byte per cycle
// while pop keeps up, into the output register. When nothing waits ahead of
// it, a result goes from its queue entry into the output register.
// Throughput is one input byte per cycle as long as bytes give at most one
// result each and pop keeps up; a byte that flushes a broken sequence occupies
// the back end for up to three result bytes; the queue absorbs that until full.
// While the receiver holds pop low the output register keeps its beat, the
// queue fills and full then stalls the sender. Reset empties the queue and
// the output register, clears any pending sequence and the mode bit.
module url_percent_decoder
    import url_dec_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       cfg_wr,
    input  logic       cfg_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       text_end
);

    entry_t wr_entry, head;
    logic   q_wr, q_full, q_rd, q_empty;

    url_dec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_entry  (wr_entry)
    );

    url_dec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (wr_entry),
        .q_full   (q_full),
        .rd       (q_rd),
        .head     (head),
        .q_empty  (q_empty)
    );

    url_dec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .rd       (q_rd),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .run_end  (run_end),
        .text_end (text_end)
    );

endmodule

// ----- src/url_dec_checker.sv -----
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends only on the ports of url_percent_decoder.
module url_dec_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       run_end,
    input logic       text_end
);

    // The end of a text always closes the run of its last input byte.
    a_text_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!text_end || run_end))
        else $error("text_end without run_end");

    // A waiting beat holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_end) &&
                              $stable(text_end)))
        else $error("output beat changed while stalled");

    // The rest of a run is already queued, so the next beat follows at once.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !run_end) |=> !empty)
        else $error("gap inside a run of results");

    // The queue can only fill through an input beat.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

endmodule

bind url_percent_decoder url_dec_checker u_chk (.*);
